// ----- rtl/core/mlfd_pkg.sv -----
// Shared types and constants of the magic/length frame deframer.
package mlfd_pkg;

   // Largest payload that the length registers can ever hold.
   localparam int PayloadLimit = 4096;
   localparam int LenW         = $clog2(PayloadLimit + 1);

   // Fixed field widths.
   localparam int ByteW     = 8;
   localparam int MagicW    = 32;
   localparam int CfgLenW   = 13;
   localparam int CountW    = 32;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 32;
   localparam int LimW      = (LenW > CfgLenW) ? LenW : CfgLenW;

   // Header window: four magic bytes and four length bytes.
   localparam int WinBytes = 8;
   localparam int WinKeep  = WinBytes - 1;
   localparam int FillW    = $clog2(WinBytes);

   // Register reset values.
   localparam logic [CfgLenW-1:0] MaxPayloadReset      = CfgLenW'(4096);
   localparam logic [MagicW-1:0]  MagicSignallingReset = 32'h544D_4153;
   localparam logic [MagicW-1:0]  MagicReportReset     = 32'h544D_4152;
   localparam logic [MagicW-1:0]  MagicVoiceReset      = 32'h544D_4443;

   typedef enum logic [1:0] {
      EV_PAYLOAD    = 2'd0,
      EV_EMPTY      = 2'd1,
      EV_BAD_MAGIC  = 2'd2,
      EV_BAD_LENGTH = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      FT_SIGNALLING = 2'd0,
      FT_REPORT     = 2'd1,
      FT_VOICE      = 2'd2
   } frame_type_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_MAX_PAYLOAD      = 2'd0,
      CSR_MAGIC_SIGNALLING = 2'd1,
      CSR_MAGIC_REPORT     = 2'd2,
      CSR_MAGIC_VOICE      = 2'd3
   } csr_index_type;

   // Outcome of one request as decided by the parser.
   typedef struct packed {
      logic                fire;
      event_kind_type      kind;
      logic [ByteW-1:0]    data;
      logic                last;
      frame_type_type      ftype;
      logic [LenW-1:0]     flen;
   } step_type;

   typedef struct packed {
      logic [CountW-1:0] good_frames;
      logic [CountW-1:0] good_bytes;
      logic [CountW-1:0] magic_drops;
      logic [CountW-1:0] length_drops;
   } cnt_type;

   typedef struct packed {
      event_kind_type   kind;
      logic [ByteW-1:0] data;
      logic             last;
      frame_type_type   ftype;
      cnt_type          cnt;
   } result_type;

endpackage

// ----- rtl/core/mlfd_ifs.sv -----
// Request and response channel interfaces of the frame deframer.
interface mlfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface mlfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  out_byte;
   logic        frame_last;
   logic [1:0]  frame_type;
   logic [31:0] good_frames;
   logic [31:0] good_bytes;
   logic [31:0] magic_drops;
   logic [31:0] length_drops;

   modport source (output valid, output event_kind, output out_byte, output frame_last,
                   output frame_type, output good_frames, output good_bytes,
                   output magic_drops, output length_drops, input ready);
   modport sink   (input valid, input event_kind, input out_byte, input frame_last,
                   input frame_type, input good_frames, input good_bytes,
                   input magic_drops, input length_drops, output ready);
endinterface

// ----- rtl/core/mlfd_parse.sv -----
// Header window, magic and length check, payload tracking and config registers.
module mlfd_parse (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic [mlfd_pkg::ByteW-1:0]           in_byte,
   input  logic                                 csr_we,
   input  logic [mlfd_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [mlfd_pkg::CsrDataW-1:0]        csr_wdata,
   output mlfd_pkg::step_type                   step
);

   logic [mlfd_pkg::CfgLenW-1:0] max_payload_ff;
   logic [mlfd_pkg::MagicW-1:0]  magic_sig_ff;
   logic [mlfd_pkg::MagicW-1:0]  magic_rep_ff;
   logic [mlfd_pkg::MagicW-1:0]  magic_voi_ff;

   logic [mlfd_pkg::ByteW-1:0] win_ff [mlfd_pkg::WinKeep];
   logic [mlfd_pkg::ByteW-1:0] win_in [mlfd_pkg::WinKeep];
   logic [mlfd_pkg::FillW-1:0] fill_ff, fill_in;
   logic                       in_payload_ff, in_payload_in;
   logic [mlfd_pkg::LenW-1:0]  remaining_ff, remaining_in;
   mlfd_pkg::frame_type_type   cur_type_ff, cur_type_in;
   logic [mlfd_pkg::LenW-1:0]  flen_ff, flen_in;

   logic [mlfd_pkg::MagicW-1:0] magic;
   logic [mlfd_pkg::MagicW-1:0] plen;
   logic [mlfd_pkg::LimW-1:0]   limit;
   logic                        full;
   logic                        known;
   mlfd_pkg::frame_type_type    mtype;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= mlfd_pkg::MaxPayloadReset;
         magic_sig_ff   <= mlfd_pkg::MagicSignallingReset;
         magic_rep_ff   <= mlfd_pkg::MagicReportReset;
         magic_voi_ff   <= mlfd_pkg::MagicVoiceReset;
      end else if (csr_we) begin
         unique case (mlfd_pkg::csr_index_type'(csr_index))
            mlfd_pkg::CSR_MAX_PAYLOAD: begin
               max_payload_ff <= csr_wdata[mlfd_pkg::CfgLenW-1:0];
            end
            mlfd_pkg::CSR_MAGIC_SIGNALLING: begin
               magic_sig_ff <= csr_wdata[mlfd_pkg::MagicW-1:0];
            end
            mlfd_pkg::CSR_MAGIC_REPORT: begin
               magic_rep_ff <= csr_wdata[mlfd_pkg::MagicW-1:0];
            end
            mlfd_pkg::CSR_MAGIC_VOICE: begin
               magic_voi_ff <= csr_wdata[mlfd_pkg::MagicW-1:0];
            end
            default: begin
               max_payload_ff <= max_payload_ff;
            end
         endcase
      end
   end

   // The eighth header byte is the incoming byte itself, so only seven are stored.
   assign magic = {win_ff[0], win_ff[1], win_ff[2], win_ff[3]};
   assign plen  = {win_ff[4], win_ff[5], win_ff[6], in_byte};
   assign full  = (fill_ff == mlfd_pkg::FillW'(mlfd_pkg::WinKeep));

   assign limit = (mlfd_pkg::LimW'(max_payload_ff) < mlfd_pkg::LimW'(mlfd_pkg::PayloadLimit))
                ? mlfd_pkg::LimW'(max_payload_ff)
                : mlfd_pkg::LimW'(mlfd_pkg::PayloadLimit);

   // Equal magic registers resolve to the lowest frame type.
   always_comb begin
      known = 1'b1;
      mtype = mlfd_pkg::FT_SIGNALLING;
      priority if (magic == magic_sig_ff) begin
         mtype = mlfd_pkg::FT_SIGNALLING;
      end else if (magic == magic_rep_ff) begin
         mtype = mlfd_pkg::FT_REPORT;
      end else if (magic == magic_voi_ff) begin
         mtype = mlfd_pkg::FT_VOICE;
      end else begin
         known = 1'b0;
      end
   end

   always_comb begin
      win_in        = win_ff;
      fill_in       = fill_ff;
      in_payload_in = in_payload_ff;
      remaining_in  = remaining_ff;
      cur_type_in   = cur_type_ff;
      flen_in       = flen_ff;

      step.fire  = 1'b0;
      step.kind  = mlfd_pkg::EV_PAYLOAD;
      step.data  = '0;
      step.last  = 1'b0;
      step.ftype = mlfd_pkg::FT_SIGNALLING;
      step.flen  = flen_ff;

      if (in_payload_ff) begin
         step.fire  = 1'b1;
         step.data  = in_byte;
         step.last  = (remaining_ff <= mlfd_pkg::LenW'(1));
         step.ftype = cur_type_ff;
         if (step.last) begin
            in_payload_in = 1'b0;
            remaining_in  = '0;
         end else begin
            remaining_in = remaining_ff - mlfd_pkg::LenW'(1);
         end
      end else if (!full) begin
         win_in[fill_ff] = in_byte;
         fill_in         = fill_ff + mlfd_pkg::FillW'(1);
      end else if (!known) begin
         // Slide by one byte and wait for the next byte to refill the window.
         for (int i = 0; i < mlfd_pkg::WinKeep - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[mlfd_pkg::WinKeep - 1] = in_byte;
         step.fire = 1'b1;
         step.kind = mlfd_pkg::EV_BAD_MAGIC;
      end else begin
         fill_in = '0;
         if (plen > mlfd_pkg::MagicW'(limit)) begin
            step.fire  = 1'b1;
            step.kind  = mlfd_pkg::EV_BAD_LENGTH;
            step.ftype = mtype;
         end else begin
            cur_type_in = mtype;
            flen_in     = plen[mlfd_pkg::LenW-1:0];
            if (plen == '0) begin
               step.fire  = 1'b1;
               step.kind  = mlfd_pkg::EV_EMPTY;
               step.last  = 1'b1;
               step.ftype = mtype;
            end else begin
               in_payload_in = 1'b1;
               remaining_in  = plen[mlfd_pkg::LenW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         in_payload_ff <= 1'b0;
         remaining_ff  <= '0;
         cur_type_ff   <= mlfd_pkg::FT_SIGNALLING;
         flen_ff       <= '0;
      end else if (take) begin
         fill_ff       <= fill_in;
         in_payload_ff <= in_payload_in;
         remaining_ff  <= remaining_in;
         cur_type_ff   <= cur_type_in;
         flen_ff       <= flen_in;
      end
   end

   // Window bytes are always written before they are read.
   always_ff @(posedge clock) begin
      if (take) begin
         win_ff <= win_in;
      end
   end

   a_remaining_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (remaining_ff != '0))
      else $error("payload active with no bytes remaining");

   a_payload_passes: assert property (@(posedge clock) disable iff (reset)
      (take && in_payload_ff) |-> (step.fire && step.kind == mlfd_pkg::EV_PAYLOAD))
      else $error("payload byte did not produce a payload event");

   a_resync_fill: assert property (@(posedge clock) disable iff (reset)
      (take && !in_payload_ff && full && step.fire && step.kind == mlfd_pkg::EV_BAD_MAGIC)
      |=> (fill_ff == mlfd_pkg::FillW'(mlfd_pkg::WinKeep) && !in_payload_ff))
      else $error("bad magic did not leave seven bytes in the window");

   a_good_header: assert property (@(posedge clock) disable iff (reset)
      (take && !in_payload_ff && full && !step.fire) |=> (in_payload_ff && fill_ff == '0))
      else $error("good header did not start a payload");

endmodule

// ----- rtl/core/mlfd_stats.sv -----
// Running frame, byte and drop counters.
module mlfd_stats (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  mlfd_pkg::step_type step,
   output mlfd_pkg::cnt_type  cnt_next
);

   mlfd_pkg::cnt_type cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (step.fire) begin
         // The last flag marks both a finished payload and an empty frame.
         if (step.last) begin
            cnt_in.good_frames = cnt_ff.good_frames + mlfd_pkg::CountW'(1);
         end
         if (step.last && step.kind == mlfd_pkg::EV_PAYLOAD) begin
            cnt_in.good_bytes = cnt_ff.good_bytes + mlfd_pkg::CountW'(step.flen);
         end
         if (step.kind == mlfd_pkg::EV_BAD_MAGIC) begin
            cnt_in.magic_drops = cnt_ff.magic_drops + mlfd_pkg::CountW'(1);
         end
         if (step.kind == mlfd_pkg::EV_BAD_LENGTH) begin
            cnt_in.length_drops = cnt_ff.length_drops + mlfd_pkg::CountW'(1);
         end
      end
   end

   assign cnt_next = cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (take) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/mlfd_outreg.sv -----
// Result register between the parser and the response channel.
module mlfd_outreg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mlfd_pkg::result_type d,
   input  logic                 out_ready,
   output logic                 out_valid,
   output mlfd_pkg::result_type q,
   output logic                 can_load
);

   logic                 valid_ff, valid_in;
   mlfd_pkg::result_type data_ff;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= d;
      end
   end

   assign out_valid = valid_ff;
   assign q         = data_ff;

endmodule

// ----- rtl/core/magic_length_frame_deframer_top.sv -----
// Top level of the magic/length prefixed frame deframer.
//
//   Channel  Direction  Handshake      Contents
//   req      in         valid/ready    in_byte, one raw stream byte per request
//   rsp      out        valid/ready    event_kind, out_byte, frame_last, frame_type, counters
//   csr      in         csr_we         csr_index selects the register, csr_wdata the value
//
// Every request is handled in the cycle it is accepted, so one byte per clock is
// sustained while rsp does not stall; the result register is the only stage, and its
// results appear in the cycle after the request. A request is taken whenever the result
// register is empty or is being drained in the same cycle, so a result that waits on rsp
// holds off every request, including header bytes that would produce no result.
// Reset is synchronous and clears the parser, the counters and the result valid flag.
// A stall on rsp holds the result and, once the register is full, holds off req.
module magic_length_frame_deframer_top (
   input  logic                                clock,
   input  logic                                reset,
   mlfd_req_if.sink                            req,
   mlfd_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [mlfd_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [mlfd_pkg::CsrDataW-1:0]       csr_wdata
);

   logic                 take;
   logic                 can_load;
   mlfd_pkg::step_type   step;
   mlfd_pkg::cnt_type    cnt_next;
   mlfd_pkg::result_type result_d;
   mlfd_pkg::result_type result_q;

   // A request is accepted whenever the result register can take what it produces.
   assign req.ready = can_load;
   assign take      = req.valid && can_load;

   // The parser decides the event for the current byte from its stored state and that byte.
   mlfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .in_byte   (req.in_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step)
   );

   // Counters report the values after this request's update.
   mlfd_stats u_stats (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .step     (step),
      .cnt_next (cnt_next)
   );

   always_comb begin
      result_d.kind  = step.kind;
      result_d.data  = step.data;
      result_d.last  = step.last;
      result_d.ftype = step.ftype;
      result_d.cnt   = cnt_next;
   end

   // Only requests that produce an event load the result register.
   mlfd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (take && step.fire),
      .d         (result_d),
      .out_ready (rsp.ready),
      .out_valid (rsp.valid),
      .q         (result_q),
      .can_load  (can_load)
   );

   assign rsp.event_kind   = result_q.kind;
   assign rsp.out_byte     = result_q.data;
   assign rsp.frame_last   = result_q.last;
   assign rsp.frame_type   = result_q.ftype;
   assign rsp.good_frames  = result_q.cnt.good_frames;
   assign rsp.good_bytes   = result_q.cnt.good_bytes;
   assign rsp.magic_drops  = result_q.cnt.magic_drops;
   assign rsp.length_drops = result_q.cnt.length_drops;

endmodule

// ----- tb/sv/magic_length_frame_deframer_top_tb.sv -----
// Self-checking testbench for the magic/length prefixed frame deframer top level.
`timescale 1ns / 100ps

module magic_length_frame_deframer_top_tb;
   import mlfd_pkg::*;

   // A request is handled in the cycle it is accepted and its response lands in
   // the result register in the cycle after. A drain ends with this many spare cycles
   // so that nothing is still in flight.
   localparam int DrainCycles = 4;

   // The run is abandoned when no request and no response has been accepted for
   // this many cycles. The longest legal quiet stretch is a receiver stall or a
   // register update with its drain, so this is far beyond it.
   localparam int IdleLimit = 1000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_wdata;

   mlfd_req_if req_if ();
   mlfd_rsp_if rsp_if ();

   magic_length_frame_deframer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The clock runs with a 2 ns period. Inputs change on the falling edge, and
   // everything is sampled on the rising edge.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Register values as the block should hold them.
   logic [CfgLenW-1:0] cfg_max_payload;
   logic [MagicW-1:0]  cfg_magic_sig;
   logic [MagicW-1:0]  cfg_magic_rep;
   logic [MagicW-1:0]  cfg_magic_voice;

   // Parser state of the deframer as predicted by the testbench.
   logic [7:0]     hdr_window [WinBytes];
   int             hdr_fill;
   bit             in_frame;
   logic [12:0]    payload_left;
   frame_type_type frame_kind;
   logic [12:0]    frame_size;
   cnt_type        stats;

   // Responses that are owed by the block, oldest first.
   result_type pending_events [$];
   result_type mon_wanted;
   result_type mon_predicted;

   int  error_count = 0;
   int  sent_count = 0;
   int  burst_left = 0;
   bit  sender_gaps = 1'b1;
   int  idle_cycles = 0;
   int  settings_count = 0;
   int  responses_seen = 0;
   int  kind_seen [4] = '{0, 0, 0, 0};

   // Receiver stall pattern state.
   int  rsp_mode = 0;
   int  rsp_mode_left = 0;
   int  rsp_hold = 0;

   // Puts the predicted parser, counters and registers back to their reset values.
   function automatic void clear_deframer();
      foreach (hdr_window[i]) hdr_window[i] = '0;
      hdr_fill        = 0;
      in_frame        = 1'b0;
      payload_left    = '0;
      frame_kind      = FT_SIGNALLING;
      frame_size      = '0;
      stats           = '0;
      cfg_max_payload = MaxPayloadReset;
      cfg_magic_sig   = MagicSignallingReset;
      cfg_magic_rep   = MagicReportReset;
      cfg_magic_voice = MagicVoiceReset;
   endfunction

   function automatic int active_limit();
      return (cfg_max_payload < PayloadLimit) ? int'(cfg_max_payload) : PayloadLimit;
   endfunction

   // Advances the predicted parser by one stream byte. Returns 1 when the byte
   // causes a response, which is then written to ev.
   function automatic bit deframe_byte(input logic [7:0] b, output result_type ev);
      logic [31:0]    magic;
      logic [31:0]    plen;
      frame_type_type ft;
      bit             is_last;
      ev = '0;
      // Inside a frame every byte is payload and passes straight through.
      if (in_frame) begin
         is_last = (payload_left <= 1);
         if (is_last) begin
            in_frame          = 1'b0;
            payload_left      = '0;
            stats.good_frames = stats.good_frames + 1;
            stats.good_bytes  = stats.good_bytes + 32'(frame_size);
         end else begin
            payload_left = payload_left - 1;
         end
         ev.kind  = EV_PAYLOAD;
         ev.data  = b;
         ev.last  = is_last;
         ev.ftype = frame_kind;
         ev.cnt   = stats;
         return 1'b1;
      end
      if (hdr_fill > WinKeep) hdr_fill = WinKeep;
      hdr_window[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill < WinBytes) return 1'b0;
      magic = {hdr_window[0], hdr_window[1], hdr_window[2], hdr_window[3]};
      // With equal registers the first match in this order decides the type.
      if (magic == cfg_magic_sig) begin
         ft = FT_SIGNALLING;
      end else if (magic == cfg_magic_rep) begin
         ft = FT_REPORT;
      end else if (magic == cfg_magic_voice) begin
         ft = FT_VOICE;
      end else begin
         // Unknown magic: only the oldest byte goes, so the next byte refills the
         // window for another try one position later.
         for (int i = 0; i < WinKeep; i++) hdr_window[i] = hdr_window[i + 1];
         hdr_window[WinKeep] = '0;
         hdr_fill            = WinKeep;
         stats.magic_drops   = stats.magic_drops + 1;
         ev.kind = EV_BAD_MAGIC;
         ev.cnt  = stats;
         return 1'b1;
      end
      plen = {hdr_window[4], hdr_window[5], hdr_window[6], hdr_window[7]};
      foreach (hdr_window[i]) hdr_window[i] = '0;
      hdr_fill = 0;
      if (plen > active_limit()) begin
         stats.length_drops = stats.length_drops + 1;
         ev.kind  = EV_BAD_LENGTH;
         ev.ftype = ft;
         ev.cnt   = stats;
         return 1'b1;
      end
      frame_kind = ft;
      frame_size = plen[12:0];
      if (plen == 0) begin
         stats.good_frames = stats.good_frames + 1;
         ev.kind  = EV_EMPTY;
         ev.last  = 1'b1;
         ev.ftype = ft;
         ev.cnt   = stats;
         return 1'b1;
      end
      in_frame     = 1'b1;
      payload_left = plen[12:0];
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Scoreboard. A response accepted at this edge belongs to a request that was
   // accepted at an earlier edge, so the response is checked before the request
   // of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         clear_deframer();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_events.size() == 0) begin
               $display("%0t: response with no request outstanding, event_kind %0d",
                        $time, rsp_if.event_kind);
               error_count++;
            end else begin
               mon_wanted = pending_events.pop_front();
               check_field("event_kind", 32'(mon_wanted.kind), 32'(rsp_if.event_kind));
               check_field("out_byte", 32'(mon_wanted.data), 32'(rsp_if.out_byte));
               check_field("frame_last", 32'(mon_wanted.last), 32'(rsp_if.frame_last));
               check_field("frame_type", 32'(mon_wanted.ftype), 32'(rsp_if.frame_type));
               check_field("good_frames", mon_wanted.cnt.good_frames, rsp_if.good_frames);
               check_field("good_bytes", mon_wanted.cnt.good_bytes, rsp_if.good_bytes);
               check_field("magic_drops", mon_wanted.cnt.magic_drops, rsp_if.magic_drops);
               check_field("length_drops", mon_wanted.cnt.length_drops,
                           rsp_if.length_drops);
               kind_seen[mon_wanted.kind]++;
               responses_seen++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (deframe_byte(req_if.in_byte, mon_predicted))
               pending_events.push_back(mon_predicted);
         end
      end
   end

   // Watchdog: a hung handshake on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("%0t: nothing accepted for %0d cycles", $time, idle_cycles);
         $display("magic_length_frame_deframer_top regression: fail");
         $finish;
      end
   end

   // The receiver switches between three behaviors: always ready, ready at random with
   // probability three in four, and alternating long stalls with short ready windows.
   always @(negedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_mode      = $urandom_range(0, 2);
         rsp_mode_left = $urandom_range(20, 200);
      end
      rsp_mode_left--;
      case (rsp_mode)
         0: begin
            rsp_if.ready = 1'b1;
         end
         1: begin
            rsp_if.ready = ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (rsp_hold <= 0) begin
               rsp_if.ready = !rsp_if.ready;
               rsp_hold     = rsp_if.ready ? $urandom_range(1, 10) : $urandom_range(1, 20);
            end
            rsp_hold--;
         end
      endcase
   end

   // Sends one stream byte as a request and returns once it has been accepted.
   // The sender works in bursts; between bursts valid drops for a random gap
   // unless gaps are switched off for the current stretch.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = sender_gaps ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_if.valid   = 1'b1;
      req_if.in_byte = b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   // Sends a 32-bit word most significant byte first, as the header is laid out.
   task automatic send_word(input logic [31:0] w);
      send_byte(w[31:24]);
      send_byte(w[23:16]);
      send_byte(w[15:8]);
      send_byte(w[7:0]);
   endtask

   // Stops sending and waits until every owed response has been accepted. The
   // extra cycles cover a request that was still being parsed without a response.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      burst_left   = 0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      case (idx)
         CSR_MAX_PAYLOAD:      cfg_max_payload = value[CfgLenW-1:0];
         CSR_MAGIC_SIGNALLING: cfg_magic_sig   = value;
         CSR_MAGIC_REPORT:     cfg_magic_rep   = value;
         CSR_MAGIC_VOICE:      cfg_magic_voice = value;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Registers are only rewritten once the block has nothing left to deliver.
   task automatic set_registers(input logic [CfgLenW-1:0] max_len, input logic [31:0] m_sig,
                                input logic [31:0] m_rep, input logic [31:0] m_voice);
      wait_drained();
      write_csr(CSR_MAX_PAYLOAD, 32'(max_len));
      write_csr(CSR_MAGIC_SIGNALLING, m_sig);
      write_csr(CSR_MAGIC_REPORT, m_rep);
      write_csr(CSR_MAGIC_VOICE, m_voice);
      settings_count++;
   endtask

   function automatic logic [31:0] magic_of(input int ft);
      case (ft)
         0:       return cfg_magic_sig;
         1:       return cfg_magic_rep;
         default: return cfg_magic_voice;
      endcase
   endfunction

   // Picks a header length around the active limit: empty frames, short frames,
   // exactly the limit when that is cheap to send, one past it, and huge values.
   function automatic logic [31:0] pick_length(input int limit);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return 32'd0;
      if (sel < 20) return 32'(limit + 1);
      if (sel < 25) return $urandom() | 32'h0001_0000;
      if (sel < 35 && limit <= 64) return 32'(limit);
      if (limit == 0) return 32'd0;
      return 32'($urandom_range(1, (limit < 16) ? limit : 16));
   endfunction

   // Random stream. Most of it is well-formed frames with random type, length and
   // payload; the rest is stray bytes, magic words cut short, and pauses in which
   // the sender waits for every owed response.
   task automatic random_traffic(input int n_items);
      int          stop_at;
      int          sel;
      int          n;
      int          limit;
      logic [31:0] magic;
      logic [31:0] plen;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         sel   = $urandom_range(0, 99);
         limit = active_limit();
         if (sel < 72) begin
            magic = magic_of($urandom_range(0, 2));
            plen  = pick_length(limit);
            send_word(magic);
            send_word(plen);
            if (plen <= limit) repeat (plen) send_byte(8'($urandom()));
         end else if (sel < 84) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
         end else if (sel < 96) begin
            magic = magic_of($urandom_range(0, 2));
            n     = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) send_byte(magic[31 - 8 * i -: 8]);
         end else begin
            wait_drained();
         end
      end
   endtask

   // Directed frames at the reset register values.
   task automatic test_directed_defaults();
      // A stray zero byte ahead of a report header makes the first full window
      // fail; after the drop the window resyncs on the real header, whose one
      // payload byte is all ones.
      send_byte(8'h00);
      send_word(MagicReportReset);
      send_word(32'd1);
      send_byte(8'hFF);
      // A voice header with zero length gives a single empty-frame response.
      send_word(MagicVoiceReset);
      send_word(32'd0);
      // One byte past the payload limit drops the whole signalling header.
      send_word(MagicSignallingReset);
      send_word(32'(PayloadLimit + 1));
   endtask

   // A limit register above the payload limit is clamped to it: one byte past the
   // payload limit is still dropped while ordinary frames pass.
   task automatic test_clamped_limit();
      set_registers('1, MagicSignallingReset, MagicReportReset, MagicVoiceReset);
      send_word(MagicSignallingReset);
      send_word(32'(PayloadLimit + 1));
      random_traffic(100);
   endtask

   // With a zero limit only empty frames get through.
   task automatic test_zero_limit();
      set_registers('0, $urandom(), $urandom(), $urandom());
      random_traffic(150);
   endtask

   // Small random limits put the boundary within reach of short frames.
   task automatic test_small_limit();
      set_registers(CfgLenW'($urandom_range(1, 24)), $urandom(), $urandom(), $urandom());
      random_traffic(100);
      set_registers(CfgLenW'(1), $urandom(), $urandom(), $urandom());
      random_traffic(100);
   endtask

   // Extreme magic values, two of them equal so that the lower type must win.
   task automatic test_equal_magics();
      set_registers(CfgLenW'(PayloadLimit), 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      random_traffic(125);
      set_registers(CfgLenW'(40), 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      random_traffic(125);
   endtask

   // Back to the reset values, first with a sender that leaves no gaps between bursts.
   task automatic test_default_restore();
      set_registers(MaxPayloadReset, MagicSignallingReset, MagicReportReset,
                    MagicVoiceReset);
      sender_gaps = 1'b0;
      random_traffic(100);
      sender_gaps = 1'b1;
      random_traffic(100);
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_MAX_PAYLOAD;
      csr_wdata      = '0;

      // Reset is held from time zero and released on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      settings_count = 1;

      test_directed_defaults();
      test_clamped_limit();
      test_zero_limit();
      test_small_limit();
      test_equal_magics();
      test_default_restore();

      wait_drained();

      $display("Sent %0d stream bytes under %0d register settings; checked %0d responses.",
               sent_count, settings_count, responses_seen);
      $display("Payload bytes %0d, empty frames %0d, bad magic drops %0d, bad length drops %0d.",
               kind_seen[EV_PAYLOAD], kind_seen[EV_EMPTY], kind_seen[EV_BAD_MAGIC],
               kind_seen[EV_BAD_LENGTH]);
      if (error_count == 0) begin
         $display("magic_length_frame_deframer_top regression: pass");
      end else begin
         $display("magic_length_frame_deframer_top regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mlfd_pkg.sv
rtl/core/mlfd_ifs.sv
rtl/core/mlfd_parse.sv
rtl/core/mlfd_stats.sv
rtl/core/mlfd_outreg.sv
rtl/core/magic_length_frame_deframer_top.sv
tb/sv/magic_length_frame_deframer_top_tb.sv
